// ===== rtl/fct_pkg.sv =====
// ============================================================================
// fct_pkg
// Shared types and constants for the frustum plane test block.
// ============================================================================
package fct_pkg;

    localparam int NUM_PLANES_DEF = 6;
    localparam int COORD_BITS_DEF = 32;
    localparam int BOX_CORNERS    = 8;
    localparam int PLANE_W        = 3;      // covers up to eight planes
    localparam int CNT_W          = 4;
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
    localparam logic [2:0] CORNER_FIRST = 3'd0;
    localparam logic [2:0] CORNER_LAST  = 3'(BOX_CORNERS - 1);

    // s_axis_tdata layout, lowest bit first
    localparam int SLOT_LO   = 0;
    localparam int VALUE_LO  = 5;
    localparam int X_LO      = 37;
    localparam int Y_LO      = 69;
    localparam int Z_LO      = 101;
    localparam int RAD_LO    = 133;
    localparam int CORNER_LO = 164;
    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = 8;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_POINT  = 2'd1,
        KIND_SPHERE = 2'd2,
        KIND_BOX    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_INSIDE    = 2'd0,
        VERDICT_INTERSECT = 2'd1,
        VERDICT_OUTSIDE   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        TEST_POINT  = 2'd0,
        TEST_SPHERE = 2'd1,
        TEST_BOX    = 2'd2
    } t_test;

    typedef enum logic [1:0] {
        COEF_A = 2'd0,
        COEF_B = 2'd1,
        COEF_C = 2'd2,
        COEF_D = 2'd3
    } t_coef_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_HOLD
    } t_state;

    // coefficient read tag, follows the memory read down the pipe
    typedef struct packed {
        logic               vld;
        logic [PLANE_W-1:0] plane;
        t_coef_sel          sel;
        logic               last;
    } t_issue;

    // per-plane distance classification
    typedef struct packed {
        logic               vld;
        logic [PLANE_W-1:0] plane;
        logic               last;
        logic               neg;
        logic               below_r;
        logic               near;
    } t_plane_res;

    typedef struct packed {
        logic done;
        logic all_behind;
        logic none_behind;
    } t_box_stat;

endpackage

// ===== rtl/frustum_cull_test.sv =====
// ============================================================================
// frustum_cull_test
// Point, sphere and box-corner classification against stored clip planes.
// ============================================================================
// A coefficient load is taken without leaving idle and gives no result. A point,
// sphere or box-corner request reads the plane coefficients one per cycle
// from the single read port of the coefficient memory, then drains the
// distance and count pipes. A request keeps s_axis_tready low from
// acceptance until it is done, so no new request is taken while one is in
// flight; a box corner that does not report skips the output hold and
// frees it sooner. The result sits in an output register and the
// next request is taken while it waits; a reporting request stays busy
// longer only while the previous result is still unread. Box corners update
// per-plane behind counts kept in a small memory; the corner with index 7
// reports.
module frustum_cull_test #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF,
    parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // slot[4:0], coef_value[36:5], x[68:37], y[100:69], z[132:101],
    // radius[163:133], corner_index[166:164], zero pad[167]
    input  logic [fct_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // verdict[1:0], zero pad[7:2]
    output logic [fct_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // test_kind[1:0]
    output logic [1:0]                    m_axis_tuser
);
    import fct_pkg::*;

    localparam int DEPTH = NUM_PLANES * 4;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    t_kind                   r_kind;
    logic [2:0]              r_corner;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;
    logic [30:0]             r_rad;
    logic [PLANE_W-1:0]      r_plane;
    t_coef_sel               r_sel;
    logic                    r_any_neg, r_any_out, r_any_near;
    logic                    r_out_vld;
    t_verdict                r_out_verdict;
    t_test                   r_out_test;

    t_kind      w_kind;
    logic [4:0] w_slot;
    logic       w_accept, w_start, w_load_ok, w_last_rd, w_want, w_out_free;
    logic       w_issue_en, w_out_load;
    t_issue     w_issue;
    logic [31:0] w_coef;
    t_plane_res w_res;
    t_box_stat  w_stat;
    t_verdict   w_verdict;
    t_test      w_test;

    assign w_kind    = t_kind'(s_axis_tuser);
    assign w_slot    = s_axis_tdata[SLOT_LO +: 5];
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_start   = w_accept && w_kind != KIND_LOAD;
    assign w_load_ok = w_accept && w_kind == KIND_LOAD && ({1'b0, w_slot} < 6'(DEPTH));
    assign w_last_rd = (r_plane == PLANE_W'(NUM_PLANES - 1)) && r_sel == COEF_D;
    assign w_want    = r_kind != KIND_BOX || r_corner == CORNER_LAST;
    assign w_out_free = !r_out_vld || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_start) n_state = ST_ISSUE;
            ST_ISSUE: if (w_last_rd) n_state = ST_WAIT;
            ST_WAIT: begin
                if (w_stat.done) begin
                    n_state = w_want ? ST_HOLD : ST_IDLE;
                end
            end
            ST_HOLD:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_issue_en    = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_ISSUE: w_issue_en = 1'b1;
            ST_HOLD:  w_out_load = w_out_free;
            default:  ;
        endcase
    end

    always_comb begin
        case (r_kind)
            KIND_POINT: begin
                w_test    = TEST_POINT;
                w_verdict = r_any_neg ? VERDICT_OUTSIDE : VERDICT_INSIDE;
            end
            KIND_SPHERE: begin
                w_test    = TEST_SPHERE;
                w_verdict = r_any_out  ? VERDICT_OUTSIDE :
                            r_any_near ? VERDICT_INTERSECT : VERDICT_INSIDE;
            end
            default: begin
                w_test    = TEST_BOX;
                w_verdict = w_stat.all_behind  ? VERDICT_OUTSIDE :
                            w_stat.none_behind ? VERDICT_INSIDE : VERDICT_INTERSECT;
            end
        endcase
    end

    assign w_issue.vld   = w_issue_en;
    assign w_issue.plane = r_plane;
    assign w_issue.sel   = r_sel;
    assign w_issue.last  = w_last_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_plane    <= '0;
            r_sel      <= COEF_A;
            r_any_neg  <= 1'b0;
            r_any_out  <= 1'b0;
            r_any_near <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_plane <= '0;
                r_sel   <= COEF_A;
            end else if (w_issue_en) begin
                r_sel <= t_coef_sel'(r_sel + 2'd1);
                if (r_sel == COEF_D) begin
                    r_plane <= r_plane + 1'b1;
                end
            end
            if (w_start) begin
                r_any_neg  <= 1'b0;
                r_any_out  <= 1'b0;
                r_any_near <= 1'b0;
            end else if (w_res.vld) begin
                r_any_neg  <= r_any_neg  || w_res.neg;
                r_any_out  <= r_any_out  || w_res.below_r;
                r_any_near <= r_any_near || w_res.near;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_kind   <= w_kind;
            r_corner <= s_axis_tdata[CORNER_LO +: 3];
            r_x      <= s_axis_tdata[X_LO +: COORD_BITS];
            r_y      <= s_axis_tdata[Y_LO +: COORD_BITS];
            r_z      <= s_axis_tdata[Z_LO +: COORD_BITS];
            r_rad    <= s_axis_tdata[RAD_LO +: 31];
        end
        if (w_out_load) begin
            r_out_verdict <= w_verdict;
            r_out_test    <= w_test;
        end
    end

    fct_coef_mem #(
        .NUM_PLANES (NUM_PLANES)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_load_ok),
        .i_waddr (w_slot[AW-1:0]),
        .i_wdata (s_axis_tdata[VALUE_LO +: 32]),
        .i_raddr (AW'({r_plane, r_sel})),
        .o_q     (w_coef)
    );

    fct_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (w_issue),
        .i_coef   (w_coef),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_z      (r_z),
        .i_radius (r_rad),
        .o_res    (w_res)
    );

    fct_box_count #(
        .NUM_PLANES (NUM_PLANES)
    ) u_box_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_clear  (w_start && w_kind == KIND_BOX &&
                   s_axis_tdata[CORNER_LO +: 3] == CORNER_FIRST),
        .i_is_box (r_kind == KIND_BOX),
        .i_final  (r_corner == CORNER_LAST),
        .i_res    (w_res),
        .o_stat   (w_stat)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = M_DATA_W'(r_out_verdict);
    assign m_axis_tuser  = r_out_test;

endmodule

// ===== rtl/fct_coef_mem.sv =====
// ============================================================================
// fct_coef_mem
// Plane coefficient store, one write and one registered read per cycle.
// ============================================================================
module fct_coef_mem #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [$clog2(NUM_PLANES*4)-1:0]      i_waddr,
    input  logic [31:0]                          i_wdata,
    input  logic [$clog2(NUM_PLANES*4)-1:0]      i_raddr,
    output logic [31:0]                          o_q
);
    import fct_pkg::*;

    localparam int DEPTH = NUM_PLANES * 4;

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_written;
    logic [31:0]      r_q;
    logic             r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (i_we) begin
                r_written[i_waddr] <= 1'b1;
            end
            r_q_vld <= r_written[i_raddr];
        end
    end

    // entries never loaded read as zero
    assign o_q = r_q_vld ? r_q : 32'd0;

endmodule

// ===== rtl/fct_dist.sv =====
// ============================================================================
// fct_dist
// Multiply-accumulate pipe: one coefficient per cycle, one plane distance
// per four coefficients, classified against zero and the sphere radius.
// ============================================================================
module fct_dist #(
    parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fct_pkg::t_issue               i_issue,
    input  logic [31:0]                   i_coef,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_y,
    input  logic signed [COORD_BITS-1:0]  i_z,
    input  logic [30:0]                   i_radius,
    output fct_pkg::t_plane_res           o_res
);
    import fct_pkg::*;

    localparam int MW    = 32 + COORD_BITS;
    localparam int ACC_W = MW + 2;

    t_issue                   r_tag1, r_tag2, r_tag3;
    logic signed [MW-1:0]     r_prod;
    logic signed [ACC_W-1:0]  r_acc, r_dist;
    t_plane_res               r_res;

    logic signed [31:0]          w_coef;
    logic signed [COORD_BITS-1:0] w_coord;
    logic signed [MW-1:0]        w_mul, n_prod;
    logic signed [ACC_W-1:0]     w_sum, w_rr, w_dp, w_dm;

    assign w_coef = i_coef;

    always_comb begin
        case (r_tag1.sel)
            COEF_A:  w_coord = i_x;
            COEF_B:  w_coord = i_y;
            default: w_coord = i_z;
        endcase
        w_mul = w_coef * w_coord;
        if (r_tag1.sel == COEF_D) begin
            n_prod = MW'(w_coef) <<< 16;
        end else begin
            n_prod = w_mul;
        end
    end

    assign w_sum = ((r_tag2.sel == COEF_A) ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);

    assign w_rr = ACC_W'({i_radius, 16'd0});
    assign w_dp = r_dist + w_rr;
    assign w_dm = r_dist - w_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_res  <= '0;
        end else begin
            r_tag1 <= i_issue;
            r_tag2 <= r_tag1;
            r_tag3.vld   <= r_tag2.vld && r_tag2.sel == COEF_D;
            r_tag3.plane <= r_tag2.plane;
            r_tag3.sel   <= r_tag2.sel;
            r_tag3.last  <= r_tag2.last;
            r_res.vld     <= r_tag3.vld;
            r_res.plane   <= r_tag3.plane;
            r_res.last    <= r_tag3.last;
            r_res.neg     <= r_dist[ACC_W-1];
            r_res.below_r <= w_dp[ACC_W-1];
            r_res.near    <= !w_dp[ACC_W-1] && (w_dp != '0) && w_dm[ACC_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_tag2.vld) begin
            r_acc <= w_sum;
        end
        if (r_tag2.vld && r_tag2.sel == COEF_D) begin
            r_dist <= w_sum;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/fct_box_count.sv =====
// ============================================================================
// fct_box_count
// Per-plane behind counts for box corners: read, bump, write back.
// ============================================================================
module fct_box_count #(
    parameter int NUM_PLANES = fct_pkg::NUM_PLANES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,   // new test request taken
    input  logic                  i_clear,   // first corner taken
    input  logic                  i_is_box,
    input  logic                  i_final,   // last corner of the box
    input  fct_pkg::t_plane_res   i_res,
    output fct_pkg::t_box_stat    o_stat
);
    import fct_pkg::*;

    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    logic [CNT_W-1:0]      r_mem [NUM_PLANES];
    logic [NUM_PLANES-1:0] r_cnt_vld;
    logic [CNT_W-1:0]      r_q;
    logic                  r_q_vld;
    logic                  r_u_vld, r_u_last, r_u_neg;
    logic [PW-1:0]         r_u_plane;
    logic                  r_done, r_all, r_none;

    logic [PW-1:0]    w_rplane;
    logic [CNT_W-1:0] w_cnt, w_new;
    logic             w_upd;

    assign w_rplane = i_res.plane[PW-1:0];
    assign w_cnt    = r_q_vld ? r_q : '0;
    assign w_new    = (r_u_neg && w_cnt != CNT_MAX) ? w_cnt + 1'b1 : w_cnt;
    assign w_upd    = r_u_vld && i_is_box;

    always_ff @(posedge i_clk) begin
        r_q       <= r_mem[w_rplane];
        r_u_plane <= w_rplane;
        r_u_neg   <= i_res.neg;
        r_u_last  <= i_res.last;
        if (w_upd) begin
            r_mem[r_u_plane] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_q_vld   <= 1'b0;
            r_u_vld   <= 1'b0;
            r_done    <= 1'b0;
            r_all     <= 1'b0;
            r_none    <= 1'b1;
        end else begin
            r_q_vld <= r_cnt_vld[w_rplane];
            r_u_vld <= i_res.vld;
            r_done  <= r_u_vld && r_u_last;
            if (i_clear) begin
                r_cnt_vld <= '0;
            end else if (w_upd) begin
                if (r_u_last && i_final) begin
                    r_cnt_vld <= '0;
                end else begin
                    r_cnt_vld[r_u_plane] <= 1'b1;
                end
            end
            if (i_start) begin
                r_all  <= 1'b0;
                r_none <= 1'b1;
            end else if (w_upd) begin
                r_all  <= r_all || (w_new >= CNT_W'(BOX_CORNERS));
                r_none <= r_none && (w_new == '0);
            end
        end
    end

    assign o_stat.done        = r_done;
    assign o_stat.all_behind  = r_all;
    assign o_stat.none_behind = r_none;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for frustum_cull_test: streams plane loads and point,
// sphere and box-corner requests under random flow control on both sides,
// and compares every verdict with a cycle-free model of the plane tests.
// ============================================================================
module testbench;
    import fct_pkg::*;

    localparam int NUM_PLANES  = NUM_PLANES_DEF;
    localparam int NUM_COEFS   = 4 * NUM_PLANES;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 336;
    localparam int unsigned ONE_FX      = 32'h0001_0000;
    localparam int unsigned NORMAL_SPAN = 32'h0001_0000;   // +-1.0
    localparam int unsigned D_SPAN      = 32'h0050_0000;   // 0 .. 80.0
    localparam int unsigned COORD_SPAN  = 32'h0028_0000;   // +-40.0
    localparam int unsigned EXT_SPAN    = 32'h0010_0000;   // box half size up to 16.0
    localparam int unsigned RADIUS_SPAN = 32'h0020_0000;

    typedef logic signed [67:0] distance_t;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  slot;
        logic [31:0] coef;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] radius;
        logic [2:0]  corner;
    } cull_request_t;

    typedef struct packed {
        t_verdict verdict;
        t_test    test;
    } cull_result_t;

    class cull_scoreboard;
        logic signed [31:0] plane_coef [NUM_COEFS];
        logic [CNT_W-1:0]   behind_count [NUM_PLANES];
        cull_result_t       pending_verdicts [$];
        int                 fails;

        function new();
            foreach (plane_coef[i]) plane_coef[i] = '0;
            foreach (behind_count[i]) behind_count[i] = '0;
            fails = 0;
        endfunction

        // exact a*x + b*y + c*z + d in Q36.32
        function distance_t plane_distance(int p, logic signed [31:0] x,
                                           logic signed [31:0] y, logic signed [31:0] z);
            distance_t acc;
            acc = longint'(plane_coef[4*p + COEF_A]) * longint'(x);
            acc = acc + longint'(plane_coef[4*p + COEF_B]) * longint'(y);
            acc = acc + longint'(plane_coef[4*p + COEF_C]) * longint'(z);
            acc = acc + (longint'(plane_coef[4*p + COEF_D]) <<< 16);
            return acc;
        endfunction

        function void note_request(cull_request_t r);
            distance_t    distance, d_plus, d_minus;
            longint       rad;
            bit           any_out, any_near, all_behind, none_behind;
            cull_result_t res;
            case (r.kind)
                KIND_LOAD: begin
                    if (r.slot < NUM_COEFS) plane_coef[r.slot] = r.coef;
                end
                KIND_POINT: begin
                    res.verdict = VERDICT_INSIDE;
                    res.test    = TEST_POINT;
                    for (int p = 0; p < NUM_PLANES; p++)
                        if (plane_distance(p, r.x, r.y, r.z) < 0) res.verdict = VERDICT_OUTSIDE;
                    pending_verdicts.push_back(res);
                end
                KIND_SPHERE: begin
                    rad      = longint'(r.radius) <<< 16;
                    any_out  = 1'b0;
                    any_near = 1'b0;
                    for (int p = 0; p < NUM_PLANES; p++) begin
                        distance = plane_distance(p, r.x, r.y, r.z);
                        d_plus   = distance + rad;
                        d_minus  = distance - rad;
                        if (d_plus < 0) any_out = 1'b1;
                        if (d_plus > 0 && d_minus < 0) any_near = 1'b1;
                    end
                    res.verdict = any_out ? VERDICT_OUTSIDE :
                                  any_near ? VERDICT_INTERSECT : VERDICT_INSIDE;
                    res.test    = TEST_SPHERE;
                    pending_verdicts.push_back(res);
                end
                default: begin
                    if (r.corner == CORNER_FIRST)
                        foreach (behind_count[p]) behind_count[p] = '0;
                    for (int p = 0; p < NUM_PLANES; p++)
                        if (plane_distance(p, r.x, r.y, r.z) < 0 && behind_count[p] != CNT_MAX)
                            behind_count[p]++;
                    if (r.corner == CORNER_LAST) begin
                        all_behind  = 1'b0;
                        none_behind = 1'b1;
                        foreach (behind_count[p]) begin
                            if (behind_count[p] >= BOX_CORNERS) all_behind = 1'b1;
                            if (behind_count[p] != 0) none_behind = 1'b0;
                            behind_count[p] = '0;
                        end
                        res.verdict = all_behind ? VERDICT_OUTSIDE :
                                      none_behind ? VERDICT_INSIDE : VERDICT_INTERSECT;
                        res.test    = TEST_BOX;
                        pending_verdicts.push_back(res);
                    end
                end
            endcase
        endfunction

        function void check_verdict(logic [M_DATA_W-1:0] data, logic [1:0] user);
            cull_result_t want;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: verdict %0d, test_kind %0d", data[1:0], user);
                fails++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (data[1:0] !== want.verdict) begin
                $error("verdict mismatch: expected %0d, actual %0d", want.verdict, data[1:0]);
                fails++;
            end
            if (user !== want.test) begin
                $error("test_kind mismatch: expected %0d, actual %0d", want.test, user);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = KIND_LOAD;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    cull_scoreboard sb = new();
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int request_count      = 0;
    int cycle_count        = 0;
    int idle_plan  [5] = '{0, 63, 0, 38, 0};
    int stall_plan [5] = '{0, 0, 63, 38, 0};

    frustum_cull_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check on handshake, then pick the next ready
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_verdict(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= (receiver_stall_pct == 0) ||
                             ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    function automatic logic [31:0] rand_fixed(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] rand_coord();
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 75) return rand_fixed(COORD_SPAN);
        if (mode < 90) return $urandom();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [30:0] rand_radius();
        int unsigned mode;
        mode = $urandom_range(0, 99);
        if (mode < 70) return 31'($urandom_range(0, RADIUS_SPAN));
        if (mode < 80) return '0;
        return 31'($urandom());
    endfunction

    task automatic send_request(input cull_request_t r);
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {1'b0, r.corner, r.radius, r.z, r.y, r.x, r.coef, r.slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(r);
        if (r.kind != KIND_LOAD || r.slot < NUM_COEFS) request_count++;
    endtask

    // unused fields carry random filler
    task automatic send_load(input logic [4:0] slot, input logic [31:0] value);
        cull_request_t r;
        r = '{kind: KIND_LOAD, slot: slot, coef: value, x: $urandom(), y: $urandom(),
              z: $urandom(), radius: 31'($urandom()), corner: 3'($urandom())};
        send_request(r);
    endtask

    task automatic send_probe(input t_kind kind, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [30:0] radius,
                              input logic [2:0] corner);
        cull_request_t r;
        r = '{kind: kind, slot: 5'($urandom()), coef: $urandom(), x: x, y: y, z: z,
              radius: radius, corner: corner};
        send_request(r);
    endtask

    // planes around the origin, so most probes land near some boundary
    task automatic load_frustum();
        logic [31:0] value;
        for (int s = 0; s < NUM_COEFS; s++) begin
            if ($urandom_range(0, 19) == 0)
                value = $urandom();
            else if (2'(s) == COEF_D)
                value = $urandom_range(0, D_SPAN);
            else
                value = rand_fixed(NORMAL_SPAN);
            send_load(5'(s), value);
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_load(5'($urandom_range(0, 31)),
                         $urandom_range(0, 1) ? rand_fixed(NORMAL_SPAN) : $urandom());
            1: send_probe(KIND_POINT, rand_coord(), rand_coord(), rand_coord(),
                          31'($urandom()), 3'($urandom()));
            default: send_probe(KIND_SPHERE, rand_coord(), rand_coord(), rand_coord(),
                                rand_radius(), 3'($urandom()));
        endcase
    endtask

    task automatic send_corner(input logic [2:0] idx, input logic [31:0] cx,
                               input logic [31:0] cy, input logic [31:0] cz,
                               input logic [31:0] ext);
        send_probe(KIND_BOX, idx[0] ? cx + ext : cx - ext, idx[1] ? cy + ext : cy - ext,
                   idx[2] ? cz + ext : cz - ext, 31'($urandom()), idx);
    endtask

    task automatic send_box();
        logic [31:0] cx, cy, cz, ext;
        int unsigned mode, len;
        mode = $urandom_range(0, 99);
        cx   = rand_coord();
        cy   = rand_coord();
        cz   = rand_coord();
        ext  = $urandom_range(0, EXT_SPAN);
        if (mode < 80) begin
            for (int c = 0; c < BOX_CORNERS; c++) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                send_corner(3'(c), cx, cy, cz, ext);
            end
        end else if (mode < 90) begin
            len = $urandom_range(1, 10);
            repeat (len) send_corner(3'($urandom_range(0, 7)), cx, cy, cz, ext);
        end else begin
            // long run without framing corners can drive the counts into saturation
            len = $urandom_range(9, 20);
            send_corner(CORNER_FIRST, cx, cy, cz, ext);
            repeat (len) send_corner(3'($urandom_range(1, 6)), cx, cy, cz, ext);
            send_corner(CORNER_LAST, cx, cy, cz, ext);
        end
    endtask

    task automatic random_step();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            load_frustum();
        else if (roll < 9)
            send_load(5'($urandom_range(0, 31)), $urandom());
        else if (roll < 34)
            send_probe(KIND_POINT, rand_coord(), rand_coord(), rand_coord(),
                       31'($urandom()), 3'($urandom()));
        else if (roll < 55)
            send_probe(KIND_SPHERE, rand_coord(), rand_coord(), rand_coord(),
                       rand_radius(), 3'($urandom()));
        else
            send_box();
    endtask

    // hold requests back until every verdict is in and the pipe is empty
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4 * NUM_PLANES + 16) @(posedge i_clk);
    endtask

    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero planes: every distance is exactly zero
        send_probe(KIND_POINT, 32'h0, 32'h0, 32'h0, '0, '0);
        send_probe(KIND_SPHERE, 32'h0, 32'h0, 32'h0, '0, '0);
        send_probe(KIND_SPHERE, 32'h0, 32'h0, 32'h0, 31'h7fff_ffff, '0);
        send_load(5'(4 * 0 + COEF_A), ONE_FX);
        send_load(5'(NUM_COEFS - 1), 32'h7fff_ffff);
        send_load(5'(NUM_COEFS), 32'h8000_0000);     // out of range, dropped
        send_load(5'd31, 32'hffff_ffff);
        send_probe(KIND_POINT, -ONE_FX, 32'h0, 32'h0, '0, '0);
        send_probe(KIND_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h0, '0, '0);
        send_probe(KIND_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, '0, '0);
        send_probe(KIND_SPHERE, -ONE_FX, 32'h0, 32'h0, 31'(ONE_FX / 2), '0);
        send_probe(KIND_SPHERE, -(ONE_FX / 2), 32'h0, 32'h0, 31'(ONE_FX), '0);
        send_probe(KIND_SPHERE, 2 * ONE_FX, 32'h0, 32'h0, 31'(ONE_FX), '0);
        send_probe(KIND_SPHERE, ONE_FX, 32'h0, 32'h0, 31'(ONE_FX), '0);  // touching
        for (int c = 0; c < BOX_CORNERS; c++)
            send_probe(KIND_BOX, -(c + 1) * ONE_FX, 32'h0, 32'h0, '0, 3'(c));
        send_load(5'(4 * 0 + COEF_A), 32'h8000_0000);
        send_probe(KIND_POINT, 32'h7fff_ffff, 32'h0, 32'h0, '0, '0);

        foreach (idle_plan[ph]) begin
            sender_idle_pct    = idle_plan[ph];
            receiver_stall_pct = stall_plan[ph];
            target = request_count + PHASE_ITEMS;
            load_frustum();
            while (request_count < target) random_step();
            pause_until_drained();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4 * NUM_PLANES + 16) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
